@@ design/dksc_pkg.sv @@
// Shared types, constants and alphabet lookup for the digit key shift cipher.
package dksc_pkg;

  localparam int unsigned MaxKeyDigitsDefault = 16;
  localparam int unsigned KeyDataW = 64;
  localparam int unsigned KeyLenW = 5;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CodeW = 16;
  localparam int unsigned DigitW = 4;
  localparam int unsigned IdxW = 6;
  localparam int unsigned AlphaSize = 59;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyDigits = 4'd0,
    RegKeyLength = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic             mode;
    logic [CodeW-1:0] char_code;
    logic             last_in;
  } cipher_in_t;

  typedef struct packed {
    logic [CodeW-1:0] out_code;
    logic             invalid;
    logic             last_out;
  } cipher_out_t;

  typedef struct packed {
    logic advance;
    logic last;
  } key_step_t;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
  } letter_t;

  localparam logic [CodeW-1:0] ALPHA_CODES [AlphaSize] = '{
    16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0401, 16'h0416,
    16'h0417, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
    16'h041F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426,
    16'h0427, 16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E,
    16'h042F,
    16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047, 16'h0048,
    16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F, 16'h0050,
    16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057, 16'h0058,
    16'h0059, 16'h005A
  };

  function automatic letter_t letter_index(logic [CodeW-1:0] code);
    letter_t res;
    res.hit = 1'b1;
    res.idx = '0;
    if (code >= 16'h0410 && code <= 16'h0415) begin
      res.idx = IdxW'(code - 16'h0410);
    end else if (code == 16'h0401) begin
      res.idx = IdxW'(6);
    end else if (code >= 16'h0416 && code <= 16'h042F) begin
      res.idx = IdxW'(code - 16'h0416 + 16'd7);
    end else if (code >= 16'h0041 && code <= 16'h005A) begin
      res.idx = IdxW'(code - 16'h0041 + 16'd33);
    end else begin
      res.hit = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ design/dksc_key.sv @@
// Key registers, key position counter and current digit selection.
module dksc_key #(
  parameter int unsigned MAX_KEY_DIGITS = dksc_pkg::MaxKeyDigitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [dksc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dksc_pkg::KeyDataW-1:0] cfg_data_i,
  input  dksc_pkg::key_step_t           step_i,
  output logic [dksc_pkg::DigitW-1:0]   shift_o
);
  import dksc_pkg::*;

  localparam int unsigned PosW = (MAX_KEY_DIGITS > 1) ? $clog2(MAX_KEY_DIGITS) : 1;
  localparam logic [KeyLenW-1:0] MaxLen = KeyLenW'(MAX_KEY_DIGITS);

  logic [MAX_KEY_DIGITS-1:0][DigitW-1:0] key_q;
  logic [KeyLenW-1:0] len_q;
  logic [PosW-1:0]    pos_q, pos_d, pos_sel;
  logic [KeyLenW-1:0] len_eff, nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      len_q <= KeyLenW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegKeyDigits: key_q <= cfg_data_i[MAX_KEY_DIGITS*DigitW-1:0];
        RegKeyLength: len_q <= cfg_data_i[KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_q == '0) begin
      len_eff = KeyLenW'(1);
    end else if (len_q > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = len_q;
    end
    pos_sel = (KeyLenW'(pos_q) >= len_eff) ? '0 : pos_q;
    nxt = KeyLenW'(pos_sel) + KeyLenW'(1);
    if (nxt >= len_eff || step_i.last) begin
      nxt = '0;
    end
    pos_d = step_i.advance ? nxt[PosW-1:0] : pos_q;
  end

  assign shift_o = key_q[pos_sel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ design/dksc_shift.sv @@
// Letter lookup, modular shift and reverse mapping for one word.
module dksc_shift (
  input  dksc_pkg::cipher_in_t        word_i,
  input  logic [dksc_pkg::DigitW-1:0] shift_i,
  output dksc_pkg::cipher_out_t       word_o
);
  import dksc_pkg::*;

  localparam logic [IdxW:0] Modulus = (IdxW+1)'(AlphaSize);

  letter_t         letter;
  logic [IdxW:0]   sum;
  logic [IdxW:0]   red;

  always_comb begin
    letter = letter_index(word_i.char_code);
    if (word_i.mode) begin
      sum = (IdxW+1)'(letter.idx) + Modulus - (IdxW+1)'(shift_i);
    end else begin
      sum = (IdxW+1)'(letter.idx) + (IdxW+1)'(shift_i);
    end
    red = (sum >= Modulus) ? sum - Modulus : sum;
    word_o.invalid  = !letter.hit;
    word_o.out_code = letter.hit ? ALPHA_CODES[red[IdxW-1:0]] : word_i.char_code;
    word_o.last_out = word_i.last_in;
  end

endmodule

@@ design/digit_key_shift_cipher.sv @@
// Top level of the digit key shift cipher: input register, shift datapath, result register.
// Takes one letter word per clock while the output is not stalled and returns one result word per
// letter. Each word passes through the input register into the result register, which loads only
// when the output is not stalled. The sustained unstalled rate is one word per cycle, set by the
// combinational lookup, add and modulo-59 reduction between the input and result registers.
// The key position steps as a word moves into the result register and restarts after a word
// marked last. Configuration writes are always ready and take effect on the next cycle; write
// them only while no word is in flight. There is no clearing pass after reset.
module digit_key_shift_cipher #(
  parameter int unsigned MAX_KEY_DIGITS = dksc_pkg::MaxKeyDigitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dksc_pkg::cipher_in_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dksc_pkg::cipher_out_t         out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dksc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dksc_pkg::KeyDataW-1:0] cfg_data_i
);
  import dksc_pkg::*;

  cipher_in_t  s1_q;
  logic        s1_valid_q;
  cipher_out_t res, out_q;
  logic        out_valid_q;
  logic        advance;
  key_step_t   step;
  logic [DigitW-1:0] shift;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign step.advance = advance;
  assign step.last    = s1_q.last_in;

  dksc_key #(
    .MAX_KEY_DIGITS(MAX_KEY_DIGITS)
  ) u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .shift_o    (shift)
  );

  dksc_shift u_shift (
    .word_i (s1_q),
    .shift_i(shift),
    .word_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/dksc_checker.sv @@
// Port-level assertions for the digit key shift cipher and their bind.
module dksc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input dksc_pkg::cipher_out_t         out_data_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_valid_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.invalid |->
      (out_data_o.out_code >= 16'h0410 && out_data_o.out_code <= 16'h042F) ||
      (out_data_o.out_code == 16'h0401) ||
      (out_data_o.out_code >= 16'h0041 && out_data_o.out_code <= 16'h005A))
    else $error("valid result outside alphabet");

endmodule

bind digit_key_shift_cipher dksc_checker u_dksc_checker (.*);
